// ===== hdl/hit_interval_extractor_defines.svh =====
// assertion macros shared by the hit interval extractor modules
`ifndef HIT_INTERVAL_EXTRACTOR_DEFINES_SVH
`define HIT_INTERVAL_EXTRACTOR_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked on every clock out of reset
`define HIE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("hie assertion failed");
// next-cycle implication, checked on every clock out of reset
`define HIE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("hie assertion failed");
`else
`define HIE_ASSERT_IMP(lbl, ante, cons)
`define HIE_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/hie_pkg.sv =====
// types and constants shared by the hit interval extractor modules
package hie_pkg;

    // fixed field widths
    localparam int CHANNEL_W    = 2;
    localparam int HIT_W        = 32;
    localparam int TRIGGER_W    = 31;
    localparam int INTERVAL_W   = 32;
    localparam int WINDOW_W     = 10;
    localparam int LOST_BIT     = 31;

    // configuration port
    localparam int CFG_INDEX_W  = 4;
    localparam int CFG_DATA_W   = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_REJECT_LOW  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REJECT_HIGH = 4'd1;
    localparam logic [WINDOW_W-1:0] REJECT_LOW_RESET  = 10'd491;
    localparam logic [WINDOW_W-1:0] REJECT_HIGH_RESET = 10'd511;

    // queue between front and back
    localparam int QUEUE_DEPTH  = 4;

    // one input item
    typedef struct packed {
        logic [CHANNEL_W-1:0]  channel;
        logic [HIT_W-1:0]      hit_time;
        logic [TRIGGER_W-1:0]  trigger_clock;
        logic                  spill_edge;
        logic                  last_in_event;
    } hie_in_t;

    // one result item
    typedef struct packed {
        logic [INTERVAL_W-1:0] interval;
        logic                  backward;
        logic                  last_of_run;
    } hie_out_t;

    // reject window settings
    typedef struct packed {
        logic [WINDOW_W-1:0]   low;
        logic [WINDOW_W-1:0]   high;
    } window_t;

    // classified hit handed from front to back
    typedef struct packed {
        logic [INTERVAL_W-1:0] dt;
        logic                  backward;
        logic                  lost;
    } job_t;

endpackage

// ===== hdl/hie_front.sv =====
// front part: event framing, fake trigger rejection and interval computation
module hie_front #(
    parameter int CHANNELS  = 4,
    parameter int TIME_BITS = 31
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  hie_pkg::hie_in_t s_data,
    input  hie_pkg::window_t window,
    input  logic             q_full,
    output logic             push,
    output hie_pkg::job_t    job
);

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DW =
        ((TIME_BITS > hie_pkg::WINDOW_W) ? TIME_BITS : hie_pkg::WINDOW_W) + 2;
    localparam logic [TIME_BITS-1:0] WRAP_T =
        {{(TIME_BITS-1){1'b0}}, 1'b1} << (TIME_BITS - 2);
    localparam logic signed [DW-1:0] WRAP_D =
        {{(DW-1){1'b0}}, 1'b1} << (TIME_BITS - 2);
    localparam logic signed [DW-1:0] SPAN_D =
        {{(DW-1){1'b0}}, 1'b1} << TIME_BITS;

    logic [TIME_BITS-1:0] last_time_reg [CHANNELS];
    logic [CHANNELS-1:0]  seen_reg, seen_next;
    logic                 open_reg, open_next;
    logic                 muted_reg, muted_next;
    logic                 dropped_reg, dropped_next;

    logic                 accept;
    logic [CW-1:0]        ch_idx;
    logic                 in_range;
    logic                 seen_ch;
    logic                 muted_eff;
    logic                 dropped_eff;
    logic [TIME_BITS-1:0] cur;
    logic [TIME_BITS-1:0] prev;
    logic [TIME_BITS-1:0] clk_m;
    logic signed [DW-1:0] d_raw;
    logic signed [DW-1:0] d_fold;
    logic signed [DW-1:0] lo_d;
    logic signed [DW-1:0] hi_d;
    logic                 in_window;
    logic                 drop;
    logic                 store;
    logic                 emit;
    logic [TIME_BITS-1:0] fwd;
    logic [TIME_BITS-1:0] rev;
    logic                 back;

    // handshake and channel lookup
    assign s_ready  = !q_full;
    assign accept   = s_valid && s_ready;
    assign ch_idx   = CW'(s_data.channel);
    assign in_range = int'(s_data.channel) < CHANNELS;
    assign seen_ch  = in_range && seen_reg[ch_idx];
    assign prev     = last_time_reg[ch_idx];
    assign cur      = s_data.hit_time[TIME_BITS-1:0];
    assign clk_m    = TIME_BITS'(s_data.trigger_clock);

    // a hit that opens an event takes fresh event flags
    assign muted_eff   = open_reg ? muted_reg : !seen_ch;
    assign dropped_eff = open_reg && dropped_reg;

    // trigger-to-hit distance folded by one counter wrap
    assign d_raw = $signed(DW'(clk_m)) - $signed(DW'(cur));

    always_comb begin
        priority if (d_raw > WRAP_D) begin
            d_fold = d_raw - SPAN_D;
        end else if (d_raw < -WRAP_D) begin
            d_fold = d_raw + SPAN_D;
        end else begin
            d_fold = d_raw;
        end
    end

    // reject window check, an inverted window matches nothing
    assign lo_d      = $signed(DW'(window.low));
    assign hi_d      = $signed(DW'(window.high));
    assign in_window = (d_fold >= lo_d) && (d_fold <= hi_d);

    // classify the hit
    assign drop  = in_range && s_data.spill_edge && !dropped_eff && in_window;
    assign store = in_range && !drop;
    assign emit  = store && !muted_eff && seen_ch;

    // interval with wrap, small backward steps flagged
    assign fwd  = cur - prev;
    assign rev  = prev - cur;
    assign back = (cur < prev) && (rev < WRAP_T);

    assign push         = accept && emit;
    assign job.dt       = back ? '1 : 32'(fwd);
    assign job.backward = back;
    assign job.lost     = s_data.hit_time[hie_pkg::LOST_BIT];

    // next state of event and channel flags
    always_comb begin
        seen_next    = seen_reg;
        open_next    = open_reg;
        muted_next   = muted_reg;
        dropped_next = dropped_reg;
        if (accept) begin
            open_next    = !s_data.last_in_event;
            muted_next   = muted_eff;
            dropped_next = dropped_eff || drop;
            if (store) begin
                seen_next[ch_idx] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg    <= '0;
            open_reg    <= 1'b0;
            muted_reg   <= 1'b0;
            dropped_reg <= 1'b0;
        end else begin
            seen_reg    <= seen_next;
            open_reg    <= open_next;
            muted_reg   <= muted_next;
            dropped_reg <= dropped_next;
        end
    end

    // last timestamp per channel, only read once the channel has a hit
    always_ff @(posedge aclk) begin
        if (accept && store) begin
            last_time_reg[ch_idx] <= cur;
        end
    end

endmodule

// ===== hdl/hie_queue.sv =====
// short queue of classified hits between front and back
`include "hit_interval_extractor_defines.svh"
module hie_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  hie_pkg::job_t push_job,
    output logic          full,
    output logic          q_valid,
    input  logic          pop,
    output hie_pkg::job_t q_job
);

    localparam int DEPTH = hie_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);

    hie_pkg::job_t  mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]  count_reg, count_next;

    assign full    = count_reg == NW'(DEPTH);
    assign q_valid = count_reg != '0;
    assign q_job   = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    // checks
    `HIE_ASSERT_IMP(a_no_overflow, push, count_reg < NW'(DEPTH) || pop)
    `HIE_ASSERT_IMP(a_no_underflow, pop, count_reg != '0)
    `HIE_ASSERT_NXT(a_fill_up, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

// ===== hdl/hie_back.sv =====
// back part: expands each classified hit into one or two result items
`include "hit_interval_extractor_defines.svh"
module hie_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_ready,
    input  hie_pkg::job_t     q_job,
    output logic              m_valid,
    input  logic              m_ready,
    output hie_pkg::hie_out_t m_data
);

    logic              m_valid_reg, m_valid_next;
    logic              second_reg, second_next;
    hie_pkg::hie_out_t out_reg, out_next;
    logic              load_slot;
    logic              pop;

    // output slot frees when empty or taken this cycle
    assign load_slot = !m_valid_reg || m_ready;
    assign pop       = load_slot && !second_reg && q_valid;
    assign q_ready   = load_slot && !second_reg;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    // load first item, second half of a lost-marked hit, or go empty
    always_comb begin
        m_valid_next = m_valid_reg;
        second_next  = second_reg;
        out_next     = out_reg;
        if (load_slot) begin
            priority if (second_reg) begin
                out_next.last_of_run = 1'b1;
                m_valid_next         = 1'b1;
                second_next          = 1'b0;
            end else if (q_valid) begin
                out_next.interval    = q_job.lost ? (q_job.dt >> 1) : q_job.dt;
                out_next.backward    = q_job.backward;
                out_next.last_of_run = !q_job.lost;
                m_valid_next         = 1'b1;
                second_next          = q_job.lost;
            end else begin
                m_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            second_reg  <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            second_reg  <= second_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    // checks
    `HIE_ASSERT_IMP(a_first_half_shown, second_reg, m_valid_reg && !out_reg.last_of_run)
    `HIE_ASSERT_NXT(a_halves_match, m_valid_reg && m_ready && second_reg, m_valid_reg && out_reg.last_of_run && out_reg.interval == $past(out_reg.interval))
    `HIE_ASSERT_NXT(a_lost_splits, pop && q_job.lost, second_reg)

endmodule

// ===== hdl/hit_interval_extractor.sv =====
// top level of the hit interval extractor: configuration registers and part wiring
//
// Takes one hit item per clock while the queue has room and keeps, per
// channel, the last timestamp; each hit yields zero, one or two interval
// items. The front classifies a hit and updates channel and event state in
// the cycle it is accepted, so hits follow back to back at one per cycle
// while the queue is not full. A four-entry queue parts the front from the
// output stage; a result passes through the queue and the output register.
// The output stage delivers one result per cycle while m_ready is high, so
// a hit with the lost marker, which gives two half intervals, keeps it from
// taking a new hit until the second half is out. Configuration writes
// complete in the cycle they are offered.
module hit_interval_extractor #(
    parameter int CHANNELS  = 4,
    parameter int TIME_BITS = 31
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  hie_pkg::hie_in_t                 s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output hie_pkg::hie_out_t                m_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [hie_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [hie_pkg::CFG_DATA_W-1:0]   cfg_data
);

    hie_pkg::window_t window_reg, window_next;
    logic             q_full;
    logic             push;
    hie_pkg::job_t    push_job;
    logic             q_valid;
    logic             q_ready;
    hie_pkg::job_t    q_job;

    // register writes, unknown indexes ignored
    assign cfg_ready = 1'b1;

    always_comb begin
        window_next = window_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                hie_pkg::CFG_REJECT_LOW:  window_next.low  = cfg_data[hie_pkg::WINDOW_W-1:0];
                hie_pkg::CFG_REJECT_HIGH: window_next.high = cfg_data[hie_pkg::WINDOW_W-1:0];
                default:                  window_next      = window_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg.low  <= hie_pkg::REJECT_LOW_RESET;
            window_reg.high <= hie_pkg::REJECT_HIGH_RESET;
        end else begin
            window_reg <= window_next;
        end
    end

    // front: framing and classification
    hie_front #(
        .CHANNELS  (CHANNELS),
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .window  (window_reg),
        .q_full  (q_full),
        .push    (push),
        .job     (push_job)
    );

    // queue between the parts
    hie_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .q_valid  (q_valid),
        .pop      (q_valid && q_ready),
        .q_job    (q_job)
    );

    // back: result items
    hie_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_job   (q_job),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== sim/hie_checker.sv =====
// checker for the hit interval extractor: predicts interval items and compares them
module hie_checker #(
    parameter int CHANNELS  = 4,
    parameter int TIME_BITS = 31
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  hie_pkg::hie_in_t                    s_data,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  hie_pkg::hie_out_t                   m_data,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [hie_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [hie_pkg::CFG_DATA_W-1:0]      cfg_data,
    output int                                  mismatch_count,
    output int                                  pending_count
);

    localparam longint TIME_SPAN  = longint'(1) << TIME_BITS;
    localparam longint TIME_MASK  = TIME_SPAN - 1;
    localparam longint WRAP_LIMIT = longint'(1) << (TIME_BITS - 2);

    // predicted block state
    logic [TIME_BITS-1:0]         last_time [CHANNELS];
    logic                         seen_hit  [CHANNELS];
    logic                         event_open;
    logic                         event_muted;
    logic                         trigger_dropped;
    logic [hie_pkg::WINDOW_W-1:0] win_low;
    logic [hie_pkg::WINDOW_W-1:0] win_high;

    // interval items still owed by the block, oldest first
    hie_pkg::hie_out_t interval_q [$];
    hie_pkg::hie_out_t want;
    int                errors;

    // work out the interval items caused by one accepted hit
    task automatic predict_hit(input hie_pkg::hie_in_t item);
        longint   d;
        longint   prev_t;
        longint   cur_t;
        logic [hie_pkg::INTERVAL_W-1:0] dt;
        logic     back;
        logic     drop;
        int       ch;
        hie_pkg::hie_out_t res;
        ch = int'(item.channel);
        if (!event_open) begin
            event_open      = 1'b1;
            trigger_dropped = 1'b0;
            event_muted     = (ch < CHANNELS) ? !seen_hit[ch] : 1'b1;
        end
        if (ch < CHANNELS) begin
            cur_t = longint'(item.hit_time) & TIME_MASK;
            drop  = 1'b0;
            // fake trigger hit in spill-edge events, only the first one
            if (item.spill_edge && !trigger_dropped) begin
                d = (longint'(item.trigger_clock) & TIME_MASK) - cur_t;
                if (d > WRAP_LIMIT)
                    d = d - TIME_SPAN;
                else if (d < -WRAP_LIMIT)
                    d = d + TIME_SPAN;
                if (d >= longint'(win_low) && d <= longint'(win_high)) begin
                    trigger_dropped = 1'b1;
                    drop            = 1'b1;
                end
            end
            if (!drop) begin
                if (!event_muted && seen_hit[ch]) begin
                    prev_t = longint'(last_time[ch]);
                    back   = 1'b0;
                    if (cur_t >= prev_t) begin
                        dt = hie_pkg::INTERVAL_W'(cur_t - prev_t);
                    end else if (prev_t - cur_t < WRAP_LIMIT) begin
                        back = 1'b1;
                        dt   = '1;
                    end else begin
                        dt = hie_pkg::INTERVAL_W'(TIME_SPAN + cur_t - prev_t);
                    end
                    // lost marker: two half intervals
                    if (item.hit_time[hie_pkg::LOST_BIT]) begin
                        res.interval    = dt >> 1;
                        res.backward    = back;
                        res.last_of_run = 1'b0;
                        interval_q.push_back(res);
                        res.last_of_run = 1'b1;
                        interval_q.push_back(res);
                    end else begin
                        res.interval    = dt;
                        res.backward    = back;
                        res.last_of_run = 1'b1;
                        interval_q.push_back(res);
                    end
                end
                last_time[ch] = cur_t[TIME_BITS-1:0];
                seen_hit[ch]  = 1'b1;
            end
        end
        if (item.last_in_event)
            event_open = 1'b0;
    endtask

    // compare results, track configuration, predict on accepted hits
    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                last_time[i] = '0;
                seen_hit[i]  = 1'b0;
            end
            event_open      = 1'b0;
            event_muted     = 1'b0;
            trigger_dropped = 1'b0;
            win_low         = hie_pkg::REJECT_LOW_RESET;
            win_high        = hie_pkg::REJECT_HIGH_RESET;
            interval_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (interval_q.size() == 0) begin
                    if (errors < 10)
                        $display("mismatch: unexpected item interval %h backward %0b last %0b",
                                 m_data.interval, m_data.backward, m_data.last_of_run);
                    errors++;
                end else begin
                    want = interval_q.pop_front();
                    if (m_data.interval !== want.interval ||
                        m_data.backward !== want.backward ||
                        m_data.last_of_run !== want.last_of_run) begin
                        if (errors < 10)
                            $display({"mismatch: interval exp %h got %h, backward exp %0b ",
                                      "got %0b, last exp %0b got %0b"},
                                     want.interval, m_data.interval,
                                     want.backward, m_data.backward,
                                     want.last_of_run, m_data.last_of_run);
                        errors++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    hie_pkg::CFG_REJECT_LOW: begin
                        win_low = cfg_data[hie_pkg::WINDOW_W-1:0];
                    end
                    hie_pkg::CFG_REJECT_HIGH: begin
                        win_high = cfg_data[hie_pkg::WINDOW_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (s_valid && s_ready)
                predict_hit(s_data);
        end
        mismatch_count <= errors;
        pending_count  <= interval_q.size();
    end

endmodule

// ===== sim/tb_hit_interval_extractor.sv =====
// testbench top for the hit interval extractor: stimulus, watchdog and verdict
module tb_hit_interval_extractor;

    localparam int CHANNELS     = 4;
    localparam int TIME_BITS    = 31;
    localparam int PHASES       = 7;
    localparam int PHASE_ITEMS  = 230;
    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [hie_pkg::HIT_W-1:0] LOST_MARK =
        hie_pkg::HIT_W'(1) << hie_pkg::LOST_BIT;

    logic                                aclk      = 1'b0;
    logic                                aresetn   = 1'b0;
    logic                                s_valid   = 1'b0;
    logic                                s_ready;
    hie_pkg::hie_in_t                    s_data    = '0;
    logic                                m_valid;
    logic                                m_ready   = 1'b0;
    hie_pkg::hie_out_t                   m_data;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [hie_pkg::CFG_INDEX_W-1:0]     cfg_index = hie_pkg::CFG_REJECT_LOW;
    logic [hie_pkg::CFG_DATA_W-1:0]      cfg_data  = '0;

    int   mismatch_count;
    int   pending_count;
    int   quiet_cycles = 0;
    logic no_idle      = 1'b0;
    int   win_lo       = 491;
    int   win_hi       = 511;
    logic [TIME_BITS-1:0] gen_time [CHANNELS];

    hit_interval_extractor #(
        .CHANNELS  (CHANNELS),
        .TIME_BITS (TIME_BITS)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    hie_checker #(
        .CHANNELS  (CHANNELS),
        .TIME_BITS (TIME_BITS)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    // clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // watchdog on cycles with no handshake at all
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL hit_interval_extractor");
            $finish;
        end
    end

    // offer one hit item after a random gap, return once accepted
    task automatic offer_hit(input hie_pkg::hie_in_t item);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic offer_fields(input int ch, input logic [hie_pkg::HIT_W-1:0] hit,
                                input logic [hie_pkg::TRIGGER_W-1:0] trig,
                                input logic spill, input logic last);
        hie_pkg::hie_in_t item;
        item.channel       = hie_pkg::CHANNEL_W'(ch);
        item.hit_time      = hit;
        item.trigger_clock = trig;
        item.spill_edge    = spill;
        item.last_in_event = last;
        offer_hit(item);
    endtask

    // stop offering and wait until every owed interval item has come out
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // write both window registers back to back, junk in the unused upper bits
    task automatic write_window(input int lo, input int hi);
        win_lo    = lo;
        win_hi    = hi;
        cfg_valid <= 1'b1;
        cfg_index <= hie_pkg::CFG_REJECT_LOW;
        cfg_data  <= {6'($urandom), hie_pkg::WINDOW_W'(lo)};
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= hie_pkg::CFG_REJECT_HIGH;
        cfg_data  <= {6'($urandom), hie_pkg::WINDOW_W'(hi)};
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // mostly well-formed events with plausible time steps, some raw noise
    task automatic offer_random_hits(input int count);
        int      sent;
        int      len;
        int      pick;
        int      d;
        int      ch;
        logic    spill;
        logic    lost;
        logic [hie_pkg::TRIGGER_W-1:0] trig;
        logic [TIME_BITS-1:0] ts;
        hie_pkg::hie_in_t item;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 99) < 12) begin
                // noise: raw fields, framing left to chance
                len = $urandom_range(1, 4);
                repeat (len) begin
                    item.channel       = hie_pkg::CHANNEL_W'($urandom);
                    item.hit_time      = $urandom;
                    item.trigger_clock = hie_pkg::TRIGGER_W'($urandom);
                    item.spill_edge    = 1'($urandom);
                    item.last_in_event = 1'($urandom);
                    offer_hit(item);
                    sent++;
                end
            end else begin
                len   = $urandom_range(1, 8);
                spill = ($urandom_range(0, 9) < 3);
                trig  = hie_pkg::TRIGGER_W'($urandom);
                for (int i = 0; i < len; i++) begin
                    ch   = $urandom_range(0, CHANNELS - 1);
                    pick = $urandom_range(0, 19);
                    if (spill && $urandom_range(0, 2) == 0) begin
                        // place the hit near the reject window below the trigger
                        case ($urandom_range(0, 4))
                            0: d = win_lo - 1;
                            1: d = win_lo;
                            2: d = win_hi;
                            3: d = win_hi + 1;
                            default: d = $urandom_range(0, 1100);
                        endcase
                        ts = TIME_BITS'(trig) - TIME_BITS'(d);
                    end else if (pick < 12) begin
                        ts = gen_time[ch] + TIME_BITS'($urandom_range(0, 3000));
                    end else if (pick < 14) begin
                        ts = gen_time[ch] + TIME_BITS'($urandom_range(0, 32'h3FFF_FFFF));
                    end else if (pick < 16) begin
                        ts = gen_time[ch] - TIME_BITS'($urandom_range(1, 1000));
                    end else if (pick == 16) begin
                        ts = gen_time[ch] - (TIME_BITS'(1) << (TIME_BITS - 2));
                    end else if (pick == 17) begin
                        ts = gen_time[ch] - ((TIME_BITS'(1) << (TIME_BITS - 2)) - 1'b1);
                    end else begin
                        ts = TIME_BITS'($urandom);
                    end
                    lost               = ($urandom_range(0, 5) == 0);
                    item.channel       = hie_pkg::CHANNEL_W'(ch);
                    item.hit_time      = hie_pkg::HIT_W'(ts);
                    item.hit_time[hie_pkg::LOST_BIT] = lost;
                    item.trigger_clock = trig;
                    item.spill_edge    = spill;
                    item.last_in_event = (i == len - 1);
                    gen_time[ch]       = ts;
                    offer_hit(item);
                    sent++;
                end
            end
        end
    endtask

    // result side: random back-pressure plus one long hold-off
    initial begin : result_sink
        int gap;
        int taken;
        taken = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (taken == HOLD_AT) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            gap = no_idle ? 0 : $urandom_range(0, 16);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            taken++;
        end
    end

    // reset, directed hits, random phases over several windows, verdict
    initial begin : stimulus
        int lo;
        int hi;
        for (int i = 0; i < CHANNELS; i++)
            gen_time[i] = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // events opened on channels with no hit yet stay silent
        offer_fields(0, 100, 0, 0, 0);
        offer_fields(1, 200, 0, 0, 1);
        // open event: plain step, unseen channel, zero step
        offer_fields(0, 400, 0, 0, 0);
        offer_fields(3, 1000, 0, 0, 0);
        offer_fields(1, 200, 0, 0, 0);
        // lost marker: halved intervals, odd interval rounds down
        offer_fields(1, LOST_MARK | 32'd1200, 0, 0, 0);
        offer_fields(1, LOST_MARK | 32'd1201, 0, 0, 0);
        // small backward step, also with lost marker
        offer_fields(0, 390, 0, 0, 0);
        offer_fields(0, LOST_MARK | 32'd380, 0, 0, 0);
        // forward step to the largest timestamp, then across the counter wrap
        offer_fields(0, 32'h7FFF_FFFF, 0, 0, 0);
        offer_fields(0, 5, 0, 0, 0);
        // backward steps right at and just under the wrap threshold
        offer_fields(3, 1000 + 32'h2000_0000, 0, 0, 0);
        offer_fields(3, 1000, 0, 0, 0);
        offer_fields(3, 1000 + 32'h1FFF_FFFF, 0, 0, 0);
        offer_fields(3, 1000, 0, 0, 1);
        // spill edge: window edges, only the first fake trigger hit dropped
        offer_fields(0, 100000 - 490, 100000, 1, 0);
        offer_fields(1, 100000 - 512, 100000, 1, 0);
        offer_fields(2, 100000 - 491, 100000, 1, 0);
        offer_fields(0, 100000 - 500, 100000, 1, 0);
        offer_fields(1, 100000 - 511, 100000, 1, 1);
        // spill edge with the distance folded across the wrap, lost marker
        offer_fields(0, 32'hFFFF_FE0C, 0, 1, 0);
        offer_fields(1, 32'h0000_0010, 0, 1, 1);
        // all-ones fields on a channel still never stored
        offer_fields(2, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 0, 1);

        for (int phase = 0; phase < PHASES; phase++) begin
            settle();
            case (phase)
                0: begin lo = 0;    hi = 1023; end
                1: begin lo = 491;  hi = 511;  end
                2: begin lo = 1023; hi = 1023; end
                3: begin lo = 0;    hi = 0;    end
                4: begin lo = 700;  hi = 300;  end
                5: begin
                    lo = $urandom_range(0, 1023);
                    hi = $urandom_range(0, 1023);
                end
                default: begin
                    lo = $urandom_range(0, 1000);
                    hi = lo + $urandom_range(0, 23);
                end
            endcase
            write_window(lo, hi);
            no_idle = (phase == 3);
            offer_random_hits(PHASE_ITEMS);
        end
        settle();

        if (mismatch_count == 0 && pending_count == 0)
            $display("PASS hit_interval_extractor");
        else
            $display("FAIL hit_interval_extractor");
        $finish;
    end

endmodule
